>>> design/assert_macros.svh
// Shared assertion macros for the block checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> design/scc_pkg.sv
package scc_pkg;

    // Input item: raw sensor word and three current samples.
    typedef struct packed {
        logic [15:0] sensor_angle;
        logic [11:0] adc_phase_u;
        logic [11:0] adc_phase_v;
        logic [11:0] adc_phase_w;
    } scc_in_t;

    // Result item: phase compares, step, position and peak current.
    typedef struct packed {
        logic [10:0]        compare_u;
        logic [10:0]        compare_v;
        logic [10:0]        compare_w;
        logic [2:0]         sextant;
        logic signed [31:0] position;
        logic [11:0]        peak_current;
    } scc_out_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_POLE_PAIRS        = 3'd0;
    localparam logic [2:0] CFG_ELECTRICAL_OFFSET = 3'd1;
    localparam logic [2:0] CFG_INVERT_SENSOR     = 3'd2;
    localparam logic [2:0] CFG_CURRENT_LIMIT     = 3'd3;
    localparam logic [2:0] CFG_POSITION_TRACKING = 3'd4;
    localparam logic [2:0] CFG_TARGET_POSITION   = 3'd5;
    localparam logic [2:0] CFG_OPEN_LOOP_DRIVE   = 3'd6;

    // Register reset values.
    localparam logic [6:0]  POLE_PAIRS_RESET    = 7'd7;
    localparam logic [11:0] CURRENT_LIMIT_RESET = 12'd130;

    // Angle handling.
    localparam logic [15:0] ANGLE_QUARTER  = 16'd16384;
    localparam logic [15:0] WRAP_LOW       = 16'd8192;
    localparam logic [15:0] WRAP_HIGH      = 16'd24576;
    localparam logic [31:0] REVOLUTION     = 32'd32768;
    localparam logic [12:0] ADC_ZERO       = 13'd2048;

    // Position tracking duty.
    localparam logic [25:0] TRACK_DUTY_CAP = 26'd60;

    // Sextant lookup: phase advance per direction and step boundaries.
    localparam logic [14:0] ADVANCE_FORWARD = 15'd10923;
    localparam logic [14:0] ADVANCE_REVERSE = 15'd27307;
    localparam logic [14:0] SEXTANT_BOUND [5] = '{
        15'd5461, 15'd10922, 15'd16383, 15'd21844, 15'd27305
    };

    // Driven phases per sextant, bits {w, v, u}.
    localparam logic [2:0] PHASE_MAP [6] = '{
        3'b001, 3'b011, 3'b010, 3'b110, 3'b100, 3'b101
    };

endpackage

>>> design/sixstep_commutation_controller_core.sv
// Six-step commutation controller for a brushless motor.
// Input channel (in_valid / in_stall / in_data): one item per control tick,
// carrying the raw sensor angle and three phase-current samples.
// Output channel (out_valid / out_stall / out_data): one result per item,
// carrying the three phase compares, sextant, continuous position and peak
// filtered current.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
// register writes, always ready; write only while no item is in flight.
// An item is registered in the input register at the accepting edge, and its result
// is loaded into the output register once that register is free or draining.
// Throughput is one item per cycle while out_stall stays low, set by the single
// compute pass between the input register and the output register that also
// updates the angle, filter and fold-back state.
// A stalled result holds in the output register while the input register
// still takes one more item; in_stall rises only when both are full.
// Reset clears the valid flags of both registers, the unwrap and filter state
// and the fold-back, and loads the configuration registers with their defaults.
module sixstep_commutation_controller_core #(
    parameter int unsigned MAX_COMPARE  = 2047,
    parameter int unsigned FILTER_SHIFT = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  scc_pkg::scc_in_t in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output scc_pkg::scc_out_t out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    localparam int unsigned CMP_CAP_INT = (MAX_COMPARE < 2047) ? MAX_COMPARE : 2047;
    localparam logic [13:0] CMP_CAP     = 14'(CMP_CAP_INT);

    // Configuration registers
    logic [6:0]         pole_pairs_reg;
    logic [14:0]        elec_offset_reg;
    logic               invert_sensor_reg;
    logic [11:0]        current_limit_reg;
    logic               position_tracking_reg;
    logic signed [31:0] target_position_reg;
    logic signed [13:0] open_loop_drive_reg;

    // Tracking state
    logic [31:0]        rev_base_reg,   rev_base_next;
    logic [15:0]        prev_angle_reg;
    logic               first_done_reg;
    logic signed [19:0] acc_reg [3];
    logic signed [19:0] acc_next [3];
    logic [15:0]        fold_reg,       fold_next;

    // Pipeline registers
    logic               s1_valid_reg,   s1_valid_next;
    scc_pkg::scc_in_t   s1_data_reg;
    logic               out_valid_reg,  out_valid_next;
    scc_pkg::scc_out_t  out_data_reg,   out_data_next;

    logic               advance;
    logic               take;

    // Compute signals
    logic [15:0]        angle;
    logic [15:0]        prev_eff;
    logic signed [31:0] position;
    logic [22:0]        elec_prod;
    logic [14:0]        elec_raw;
    logic [14:0]        elec;
    logic [11:0]        adc [3];
    logic [19:0]        filt_mag [3];
    logic [19:0]        peak;
    logic signed [31:0] err;
    logic [31:0]        err_mag;
    logic [25:0]        err_scaled;
    logic [13:0]        duty;
    logic               reverse;
    logic [15:0]        cmp_diff;
    logic [13:0]        cmp;
    logic [10:0]        cmp_out;
    logic [14:0]        sext_sum;
    logic [2:0]         sext;
    logic [2:0]         drive_mask;

    // Handshake: the input register drains whenever the output register frees up
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign take      = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        s1_valid_next  = take | (s1_valid_reg & ~advance);
        out_valid_next = advance | (out_valid_reg & out_stall);
    end

    // Unwrap the angle into a continuous position
    always_comb
    begin
        angle    = s1_data_reg.sensor_angle + scc_pkg::ANGLE_QUARTER;
        prev_eff = first_done_reg ? prev_angle_reg : angle;
        if (prev_eff < scc_pkg::WRAP_LOW && angle > scc_pkg::WRAP_HIGH)
        begin
            rev_base_next = rev_base_reg - scc_pkg::REVOLUTION;
        end
        else if (angle < scc_pkg::WRAP_LOW && prev_eff > scc_pkg::WRAP_HIGH)
        begin
            rev_base_next = rev_base_reg + scc_pkg::REVOLUTION;
        end
        else
        begin
            rev_base_next = rev_base_reg;
        end
        position = signed'({16'd0, angle} + rev_base_next);
    end

    // Form the electrical angle, negated when the sensor is mounted reversed
    always_comb
    begin
        elec_prod = 23'(angle) * 23'(pole_pairs_reg);
        elec_raw  = elec_prod[14:0] - elec_offset_reg;
        elec      = invert_sensor_reg ? (15'd0 - elec_raw) : elec_raw;
    end

    // Leaky current filters and peak magnitude
    always_comb
    begin
        logic signed [19:0] filt;
        logic signed [12:0] sample;
        adc[0] = s1_data_reg.adc_phase_u;
        adc[1] = s1_data_reg.adc_phase_v;
        adc[2] = s1_data_reg.adc_phase_w;
        for (int i = 0; i < 3; i++)
        begin
            filt        = acc_reg[i] >>> FILTER_SHIFT;
            sample      = signed'({1'b0, adc[i]} - scc_pkg::ADC_ZERO);
            acc_next[i] = acc_reg[i] - filt + 20'(sample);
            filt_mag[i] = filt[19] ? unsigned'(-filt) : unsigned'(filt);
        end
        peak = (filt_mag[0] > filt_mag[1]) ? filt_mag[0] : filt_mag[1];
        if (filt_mag[2] > peak)
        begin
            peak = filt_mag[2];
        end
    end

    // Select duty and direction
    always_comb
    begin
        err        = target_position_reg - position;
        err_mag    = err[31] ? unsigned'(-err) : unsigned'(err);
        err_scaled = err_mag[31:6];
        if (position_tracking_reg)
        begin
            reverse = err[31] || (err == 32'sd0);
            duty    = (err_scaled > scc_pkg::TRACK_DUTY_CAP) ?
                      14'(scc_pkg::TRACK_DUTY_CAP) : 14'(err_scaled);
        end
        else
        begin
            reverse = open_loop_drive_reg[13];
            duty    = open_loop_drive_reg[13] ? unsigned'(-open_loop_drive_reg)
                                              : unsigned'(open_loop_drive_reg);
        end
    end

    // Advance the fold-back and form the compare value
    always_comb
    begin
        if (peak > {8'd0, current_limit_reg})
        begin
            fold_next = (fold_reg < {2'd0, duty}) ? fold_reg + 16'd1 : fold_reg;
        end
        else
        begin
            fold_next = (fold_reg != 16'd0) ? fold_reg - 16'd1 : fold_reg;
        end
        cmp_diff = {2'd0, duty} - fold_next;
        cmp      = ({2'd0, duty} > fold_next) ? cmp_diff[13:0] : 14'd0;
        cmp_out  = (cmp > CMP_CAP) ? CMP_CAP[10:0] : cmp[10:0];
    end

    // Look up the sextant and the driven phases
    always_comb
    begin
        sext_sum = elec + (reverse ? scc_pkg::ADVANCE_REVERSE : scc_pkg::ADVANCE_FORWARD);
        sext     = 3'd0;
        for (int k = 0; k < 5; k++)
        begin
            sext = sext + 3'(sext_sum >= scc_pkg::SEXTANT_BOUND[k]);
        end
        drive_mask = scc_pkg::PHASE_MAP[sext];
    end

    // Assemble the result
    always_comb
    begin
        out_data_next.compare_u    = drive_mask[0] ? cmp_out : 11'd0;
        out_data_next.compare_v    = drive_mask[1] ? cmp_out : 11'd0;
        out_data_next.compare_w    = drive_mask[2] ? cmp_out : 11'd0;
        out_data_next.sextant      = sext;
        out_data_next.position     = position;
        out_data_next.peak_current = peak[11:0];
    end

    // Hold control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            rev_base_reg   <= 32'd0;
            prev_angle_reg <= 16'd0;
            first_done_reg <= 1'b0;
            fold_reg       <= 16'd0;
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= 20'sd0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                rev_base_reg   <= rev_base_next;
                prev_angle_reg <= angle;
                first_done_reg <= 1'b1;
                fold_reg       <= fold_next;
                for (int i = 0; i < 3; i++)
                begin
                    acc_reg[i] <= acc_next[i];
                end
            end
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Decode configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_pairs_reg        <= scc_pkg::POLE_PAIRS_RESET;
            elec_offset_reg       <= 15'd0;
            invert_sensor_reg     <= 1'b0;
            current_limit_reg     <= scc_pkg::CURRENT_LIMIT_RESET;
            position_tracking_reg <= 1'b0;
            target_position_reg   <= 32'sd0;
            open_loop_drive_reg   <= 14'sd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                scc_pkg::CFG_POLE_PAIRS:        pole_pairs_reg        <= cfg_data[6:0];
                scc_pkg::CFG_ELECTRICAL_OFFSET: elec_offset_reg       <= cfg_data[14:0];
                scc_pkg::CFG_INVERT_SENSOR:     invert_sensor_reg     <= cfg_data[0];
                scc_pkg::CFG_CURRENT_LIMIT:     current_limit_reg     <= cfg_data[11:0];
                scc_pkg::CFG_POSITION_TRACKING: position_tracking_reg <= cfg_data[0];
                scc_pkg::CFG_TARGET_POSITION:   target_position_reg   <= signed'(cfg_data);
                scc_pkg::CFG_OPEN_LOOP_DRIVE:   open_loop_drive_reg   <= signed'(cfg_data[13:0]);
                default:
                begin
                end
            endcase
        end
    end

endmodule

>>> design/scc_checker.sv
`include "assert_macros.svh"

module scc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input scc_pkg::scc_in_t  in_data,
    input logic              out_valid,
    input logic              out_stall,
    input scc_pkg::scc_out_t out_data,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [2:0]        cfg_index,
    input logic [31:0]       cfg_data
);

    // Stalled result stays offered and unchanged
    `ASSERT_NEXT(a_out_hold_valid, clk, rst_n, out_valid && out_stall, out_valid)
    `ASSERT_NEXT(a_out_hold_data, clk, rst_n, out_valid && out_stall, $stable(out_data))

    // Sextant stays within the six steps
    `ASSERT_IMPL(a_sextant_range, clk, rst_n, out_valid, out_data.sextant <= 3'd5)

    // Undriven phases carry a zero compare
    `ASSERT_IMPL(a_v_idle, clk, rst_n, out_valid && (out_data.sextant == 3'd0 || out_data.sextant == 3'd4 || out_data.sextant == 3'd5), out_data.compare_v == 11'd0)
    `ASSERT_IMPL(a_uw_idle, clk, rst_n, out_valid && out_data.sextant == 3'd2, out_data.compare_u == 11'd0 && out_data.compare_w == 11'd0)

endmodule

bind sixstep_commutation_controller_core scc_checker u_scc_checker (.*);
